FILE: hw/rtl/sync_byte_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// deframer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SYNC_BYTE_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_BYTE_FRAME_DEFRAMER_ASSERT_SVH

// condition holds at every edge
`define SBFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SBFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// deframer package
// shared types and constants of the byte frame deframer
// ----------------------------------------------------------------------------
package sbfd_pkg;

    localparam int BUF_BYTES_DEF = 512;
    localparam int EXP_W         = 9;

    localparam logic [7:0]       SYNC_BYTE     = 8'he4;
    localparam logic [7:0]       DATA_MASK     = 8'h0c;
    localparam logic [7:0]       DATA_CODE     = 8'h04;
    localparam logic [EXP_W-1:0] SHORT_FRAME   = 9'd6;
    localparam logic [EXP_W-1:0] LONG_OVERHEAD = 9'd7;

    typedef enum logic [2:0] {
        ST_NEED_MORE = 3'd0,
        ST_FRAME     = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_CHECKSUM  = 3'd3,
        ST_READ      = 3'd4
    } status_t;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] stream_byte;
        logic [7:0] read_index;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } head_t;

endpackage

FILE: hw/rtl/sbfd_ram.sv
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sbfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/sbfd_front.sv
// ----------------------------------------------------------------------------
// deframer front end
// accepts requests, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module sbfd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_type,
    input  logic [7:0]           in_byte,
    input  logic [7:0]           in_index,
    output sbfd_pkg::head_t      head,
    input  logic                 pop
);

    sbfd_pkg::req_t entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push;
    logic       take;
    sbfd_pkg::req_t new_req;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign take     = pop && (count_reg != 2'd0);

    always_comb
    begin
        new_req.kind        = in_type ? sbfd_pkg::KIND_READ : sbfd_pkg::KIND_PUSH;
        new_req.stream_byte = in_byte;
        new_req.read_index  = in_index;
        head.valid          = (count_reg != 2'd0);
        head.req            = entry_reg[rd_ptr_reg];
        wr_ptr_next         = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next         = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next          = count_reg + 2'(push) - 2'(take);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

FILE: hw/rtl/sbfd_back.sv
// ----------------------------------------------------------------------------
// deframer back end
// executes pushes and reads against the frame buffer, runs the resync
// scan and shift, and holds the result register
// ----------------------------------------------------------------------------
`include "sync_byte_frame_deframer_assert.svh"

module sbfd_back #(
    parameter int BUF_BYTES = sbfd_pkg::BUF_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sbfd_pkg::head_t      head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sbfd_pkg::status_t    out_status,
    output logic [7:0]           out_dest,
    output logic [7:0]           out_src,
    output logic [7:0]           out_ctrl,
    output logic [7:0]           out_len,
    output logic [7:0]           out_rdata
);

    localparam int AW   = $clog2(BUF_BYTES);
    localparam int CW   = $clog2(BUF_BYTES + 1);
    localparam int CMPW = (CW > sbfd_pkg::EXP_W) ? CW : sbfd_pkg::EXP_W;
    localparam int EW   = sbfd_pkg::EXP_W;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_RD_WAIT  = 6'b000010,
        S_SCAN_RD  = 6'b000100,
        S_SCAN_CHK = 6'b001000,
        S_COPY_RD  = 6'b010000,
        S_COPY_WR  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [EW-1:0]     exp_reg, exp_next;
    logic [7:0]        xor_reg, xor_next;
    logic [7:0]        dest_reg, src_reg, ctrl_reg, len_reg;
    logic [AW-1:0]     scan_reg, scan_next;
    logic [7:0]        prev_reg, prev_next;
    logic [AW-1:0]     sh_reg, sh_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;

    logic              o_valid_reg, o_valid_next;
    sbfd_pkg::status_t o_status_reg, o_status_next;
    logic [7:0]        o_dest_reg, o_dest_next;
    logic [7:0]        o_src_reg, o_src_next;
    logic [7:0]        o_ctrl_reg, o_ctrl_next;
    logic [7:0]        o_len_reg, o_len_next;
    logic [7:0]        o_rdata_reg, o_rdata_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    logic              out_free;
    logic [CMPW-1:0]   pos;
    logic [CW-1:0]     fn;
    logic [EW-1:0]     exp_new;
    logic [7:0]        xn;
    logic [7:0]        v;

    sbfd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !o_valid_reg || out_ready;
    assign out_valid  = o_valid_reg;
    assign out_status = o_status_reg;
    assign out_dest   = o_dest_reg;
    assign out_src    = o_src_reg;
    assign out_ctrl   = o_ctrl_reg;
    assign out_len    = o_len_reg;
    assign out_rdata  = o_rdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        exp_next      = exp_reg;
        xor_next      = xor_reg;
        scan_next     = scan_reg;
        prev_next     = prev_reg;
        sh_next       = sh_reg;
        k_next        = k_reg;
        rd_addr_next  = rd_addr_reg;
        o_valid_next  = o_valid_reg && !out_ready;
        o_status_next = o_status_reg;
        o_dest_next   = o_dest_reg;
        o_src_next    = o_src_reg;
        o_ctrl_next   = o_ctrl_reg;
        o_len_next    = o_len_reg;
        o_rdata_next  = o_rdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = fill_reg[AW-1:0];
        ram_wdata     = head.req.stream_byte;
        ram_raddr     = rd_addr_reg;
        pop           = 1'b0;
        v             = head.req.stream_byte;
        pos           = CMPW'(head.req.read_index) + CMPW'(6);
        fn            = fill_reg + CW'(1);
        xn            = xor_reg ^ v;
        exp_new       = exp_reg;
        if (fn == CW'(5))
        begin
            exp_new = ((v & sbfd_pkg::DATA_MASK) == sbfd_pkg::DATA_CODE) ?
                      '0 : sbfd_pkg::SHORT_FRAME;
        end
        else if (fn == CW'(6) && exp_reg == '0)
        begin
            exp_new = sbfd_pkg::LONG_OVERHEAD + EW'(v);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop           = 1'b1;
                    o_dest_next   = '0;
                    o_src_next    = '0;
                    o_ctrl_next   = '0;
                    o_len_next    = '0;
                    o_rdata_next  = '0;
                    o_status_next = sbfd_pkg::ST_NEED_MORE;
                    if (head.req.kind == sbfd_pkg::KIND_READ)
                    begin
                        if (pos < CMPW'(BUF_BYTES))
                        begin
                            ram_raddr    = pos[AW-1:0];
                            rd_addr_next = pos[AW-1:0];
                            state_next   = S_RD_WAIT;
                        end
                        else
                        begin
                            o_valid_next  = 1'b1;
                            o_status_next = sbfd_pkg::ST_READ;
                        end
                    end
                    else
                    begin
                        o_valid_next = 1'b1;
                        if (fill_reg == '0)
                        begin
                            if (v == sbfd_pkg::SYNC_BYTE)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                fill_next = CW'(1);
                                xor_next  = v;
                            end
                        end
                        else if (fill_reg == CW'(1) && v != sbfd_pkg::SYNC_BYTE)
                        begin
                            fill_next = '0;
                            xor_next  = '0;
                        end
                        else if (fill_reg >= CW'(BUF_BYTES))
                        begin
                            o_status_next = sbfd_pkg::ST_OVERFLOW;
                            exp_next      = '0;
                            scan_next     = AW'(1);
                            state_next    = S_SCAN_RD;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            if (exp_new != '0 && CMPW'(fn) >= CMPW'(exp_new))
                            begin
                                if (xn != '0)
                                begin
                                    o_status_next = sbfd_pkg::ST_CHECKSUM;
                                    fill_next     = fn;
                                    exp_next      = '0;
                                    scan_next     = AW'(1);
                                    state_next    = S_SCAN_RD;
                                end
                                else
                                begin
                                    o_status_next = sbfd_pkg::ST_FRAME;
                                    o_dest_next   = dest_reg;
                                    o_src_next    = src_reg;
                                    o_ctrl_next   = ctrl_reg;
                                    o_len_next    = (fn == CW'(6)) ? '0 : len_reg;
                                    fill_next     = '0;
                                    xor_next      = '0;
                                    exp_next      = '0;
                                end
                            end
                            else
                            begin
                                fill_next = fn;
                                xor_next  = xn;
                                exp_next  = exp_new;
                            end
                        end
                    end
                end
            end
            S_RD_WAIT:
            begin
                if (out_free)
                begin
                    o_valid_next  = 1'b1;
                    o_status_next = sbfd_pkg::ST_READ;
                    o_rdata_next  = ram_rdata;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                ram_raddr  = scan_reg;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                prev_next = ram_rdata;
                if (scan_reg >= AW'(2) && prev_reg == sbfd_pkg::SYNC_BYTE &&
                    ram_rdata == sbfd_pkg::SYNC_BYTE)
                begin
                    sh_next    = scan_reg - AW'(1);
                    fill_next  = fill_reg - CW'(scan_reg - AW'(1));
                    k_next     = '0;
                    xor_next   = '0;
                    state_next = S_COPY_RD;
                end
                else if (CW'(scan_reg) == fill_reg - CW'(1))
                begin
                    state_next = S_IDLE;
                    if (ram_rdata == sbfd_pkg::SYNC_BYTE)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = sbfd_pkg::SYNC_BYTE;
                        fill_next = CW'(1);
                        xor_next  = sbfd_pkg::SYNC_BYTE;
                    end
                    else
                    begin
                        fill_next = '0;
                        xor_next  = '0;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + AW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_COPY_RD:
            begin
                ram_raddr  = sh_reg + k_reg;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = ram_rdata;
                xor_next  = xor_reg ^ ram_rdata;
                if (CW'(k_reg) + CW'(1) == fill_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = S_COPY_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // header shadows follow every buffer write at positions 2 to 5
    always_ff @(posedge clk)
    begin
        if (ram_we && ram_waddr == AW'(2))
        begin
            dest_reg <= ram_wdata;
        end
        if (ram_we && ram_waddr == AW'(3))
        begin
            src_reg <= ram_wdata;
        end
        if (ram_we && ram_waddr == AW'(4))
        begin
            ctrl_reg <= ram_wdata;
        end
        if (ram_we && ram_waddr == AW'(5))
        begin
            len_reg <= ram_wdata;
        end
        scan_reg     <= scan_next;
        prev_reg     <= prev_next;
        sh_reg       <= sh_next;
        k_reg        <= k_next;
        rd_addr_reg  <= rd_addr_next;
        o_status_reg <= o_status_next;
        o_dest_reg   <= o_dest_next;
        o_src_reg    <= o_src_next;
        o_ctrl_reg   <= o_ctrl_next;
        o_len_reg    <= o_len_next;
        o_rdata_reg  <= o_rdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            exp_reg     <= '0;
            xor_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            exp_reg     <= exp_next;
            xor_reg     <= xor_next;
            o_valid_reg <= o_valid_next;
        end
    end

    `SBFD_ASSERT_ALWAYS(a_fill_range, fill_reg <= CW'(BUF_BYTES), "fill count above buffer size")
    `SBFD_ASSERT_IMP(a_busy_no_pop, state_reg != S_IDLE, !pop, "request taken while busy")
    `SBFD_ASSERT_IMP(a_pop_slot, pop, out_free, "request taken with result slot occupied")
    `SBFD_ASSERT_IMP(a_copy_bound, state_reg == S_COPY_WR, CW'(k_reg) < fill_reg, "shift past fill")

endmodule

FILE: hw/rtl/sync_byte_frame_deframer.sv
// ----------------------------------------------------------------------------
// sync byte frame deframer
// cuts a byte stream into E4 E4 framed packets with xor check byte and
// serves payload reads from the frame buffer
// ----------------------------------------------------------------------------
// channel   dir   tdata                                        tuser
// s_axis    in    stream_byte, read_index                      req_type
// m_axis    out   dest_addr, src_addr, ctrl_byte, payload len,  status
//                 read_data
//
// a push is handled in the back end's idle state, a read also passes S_RD_WAIT (registered buffer read)
// a resync after overflow or checksum error scans the buffer byte by byte (S_SCAN_RD, S_SCAN_CHK)
// and, if it finds an E4 E4 pair, shifts the kept bytes down (S_COPY_RD, S_COPY_WR)
// input is queued two deep while the back end works
// rst_n clears fill count, expected length and handshake state
// the back end takes no request while the result register is held
// ----------------------------------------------------------------------------
module sync_byte_frame_deframer #(
    parameter int BUF_BYTES = sbfd_pkg::BUF_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // stream_byte, read_index
    input  logic [0:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // dest_addr, src_addr, ctrl_byte, frame_payload_len, read_data
    output logic [2:0]  m_axis_tuser   // status
);

    sbfd_pkg::head_t   head;
    logic              pop;
    sbfd_pkg::status_t status;
    logic [7:0]        dest_addr;
    logic [7:0]        src_addr;
    logic [7:0]        ctrl_byte;
    logic [7:0]        frame_payload_len;
    logic [7:0]        read_data;

    sbfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_type  (s_axis_tuser[0]),
        .in_byte  (s_axis_tdata[7:0]),
        .in_index (s_axis_tdata[15:8]),
        .head     (head),
        .pop      (pop)
    );

    sbfd_back #(
        .BUF_BYTES (BUF_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_dest   (dest_addr),
        .out_src    (src_addr),
        .out_ctrl   (ctrl_byte),
        .out_len    (frame_payload_len),
        .out_rdata  (read_data)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {read_data, frame_payload_len, ctrl_byte, src_addr, dest_addr};

endmodule
